// File: src/image_convolution_3x3_macros.svh
// Assertion macros shared by the convolution block's modules
`ifndef IMAGE_CONVOLUTION_3X3_MACROS_SVH
`define IMAGE_CONVOLUTION_3X3_MACROS_SVH
`ifndef SYNTH
// plain property, sampled on the rising edge, off during reset
`define ICV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define ICV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ICV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ICV_ASSERT(label, clk, rst_n, prop, msg)
`define ICV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ICV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/icv_pkg.sv
// Shared types and constants of the 3x3 convolution block
`default_nettype none
package icv_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIXEL_W  = 8;
  localparam int SLOTS    = 4;
  localparam int SLOT_W   = 2;
  localparam int TAP_W    = 16;
  localparam int TAPS_W   = 3 * TAP_W;
  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 16;
  localparam int PROD_W   = 25;
  localparam int RSUM_W   = 27;
  localparam int RES_W    = 28;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TAPS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_MIDDLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_BOTTOM  = 3'd4;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd256;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd256;
  localparam logic [TAPS_W-1:0]  TAPS_TOP_RST     = 48'h0;
  localparam logic [TAPS_W-1:0]  TAPS_MIDDLE_RST  = 48'h0000_0100_0000;
  localparam logic [TAPS_W-1:0]  TAPS_BOTTOM_RST  = 48'h0;

  typedef logic [PIXEL_W-1:0] pixel_t;
  // one column of the line store: a pixel for each of the four row slots
  typedef logic [SLOTS-1:0][PIXEL_W-1:0] col_word_t;

  // line store write, column address travels beside it
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    pixel_t            data;
  } wr_ctl_t;

  // per-result control handed from the sequencer to the datapath
  // masks: [0] = minus one, [1] = centre, [2] = plus one
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        row_ok;
    logic [2:0]        col_ok;
    logic              last;
  } emit_ctl_t;

  typedef struct packed {
    logic signed [RES_W-1:0] filtered_value;
    logic                    last_of_frame;
  } result_t;

endpackage
`default_nettype wire

// File: src/icv_in_if.sv
// Input stream interface: pixels and flush ticks
`default_nettype none
interface icv_in_if;
  import icv_pkg::*;
  logic         valid;
  logic         ready;
  logic         func;
  logic [PIXEL_W-1:0] pixel_value;
  modport source (output valid, func, pixel_value, input ready);
  modport sink (input valid, func, pixel_value, output ready);
endinterface
`default_nettype wire

// File: src/icv_out_if.sv
// Result stream interface: filtered values
`default_nettype none
interface icv_out_if;
  import icv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] filtered_value;
  logic                    last_of_frame;
  modport source (output valid, filtered_value, last_of_frame, input ready);
  modport sink (input valid, filtered_value, last_of_frame, output ready);
endinterface
`default_nettype wire

// File: src/icv_line_mem.sv
// Line store: four row slots per column, byte write, two registered reads
`default_nettype none
module icv_line_mem #(
  parameter int MAX_WIDTH = icv_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  icv_pkg::wr_ctl_t             wr,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_a,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_b,
  output icv_pkg::col_word_t           rd_data_a,
  output icv_pkg::col_word_t           rd_data_b
);
  import icv_pkg::*;

  col_word_t store_mem [MAX_WIDTH];
  col_word_t rd_data_a_r;
  col_word_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_mem[wr_col][wr.slot] <= wr.data;
    end
    rd_data_a_r <= store_mem[rd_col_a];
    rd_data_b_r <= store_mem[rd_col_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule
`default_nettype wire

// File: src/icv_ctrl.sv
// Position counters, result release and line store addressing
`default_nettype none
module icv_ctrl #(
  parameter int MAX_WIDTH = icv_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_func,
  input  icv_pkg::pixel_t              in_pixel,
  output logic                         in_ready,
  input  logic [icv_pkg::IMG_W_W-1:0]  image_width,
  input  logic [icv_pkg::IMG_H_W-1:0]  image_height,
  input  logic                         out_pop,
  output icv_pkg::wr_ctl_t             wr,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_col_a,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_col_b,
  output icv_pkg::emit_ctl_t           emit_b,
  output logic [$clog2(MAX_WIDTH)-1:0] emit_col_b
);
  import icv_pkg::*;

  `include "image_convolution_3x3_macros.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 3);
  localparam int XW = (EW > IMG_W_W) ? EW : IMG_W_W;
  localparam int RW = IMG_H_W + 1;

  logic [CW-1:0]      icol_r, icol_nxt, ocol_r, ocol_nxt;
  logic [IMG_H_W-1:0] irow_r, irow_nxt, orow_r, orow_nxt;
  logic [SLOT_W-1:0]  in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PW-1:0]      pending_r, pending_nxt;
  logic [COUNT_W-1:0] credit_r, credit_nxt;
  emit_ctl_t          emit_b_r, emit_ctl;
  logic [CW-1:0]      emit_col_b_r;

  logic [XW-1:0]      wx;
  logic [EW-1:0]      w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic               accept, pix_acc, emit_now;
  logic [EW-1:0]      icol_inc, ocol_inc, ocol_e;
  logic [RW-1:0]      irow_inc, orow_inc, orow_e, h_e;

  // effective geometry: zero counts as one, width clamps to the store
  always_comb begin
    wx = XW'(image_width);
    if (wx == '0) begin
      w_eff = EW'(1);
    end else if (wx > XW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(wx);
    end
    h_eff = (image_height == '0) ? IMG_H_W'(1) : image_height;
  end

  assign in_ready = credit_r < COUNT_W'(FIFO_DEPTH);
  assign accept   = in_valid && in_ready;
  assign pix_acc  = accept && !in_func;

  always_comb begin
    if (pix_acc) begin
      emit_now = pending_r > PW'(w_eff);
    end else begin
      emit_now = accept && icol_r == '0 && irow_r == '0 && pending_r != '0;
    end
  end

  assign icol_inc = EW'(icol_r) + EW'(1);
  assign ocol_inc = EW'(ocol_r) + EW'(1);
  assign irow_inc = RW'(irow_r) + RW'(1);
  assign orow_inc = RW'(orow_r) + RW'(1);
  assign ocol_e   = EW'(ocol_r);
  assign orow_e   = RW'(orow_r);
  assign h_e      = RW'(h_eff);

  always_comb begin
    icol_nxt     = icol_r;
    irow_nxt     = irow_r;
    in_slot_nxt  = in_slot_r;
    ocol_nxt     = ocol_r;
    orow_nxt     = orow_r;
    out_slot_nxt = out_slot_r;
    pending_nxt  = pending_r;
    credit_nxt   = credit_r;

    if (pix_acc) begin
      if (icol_inc >= w_eff) begin
        icol_nxt    = '0;
        in_slot_nxt = in_slot_r + SLOT_W'(1);
        irow_nxt    = (irow_inc >= h_e) ? '0 : irow_inc[IMG_H_W-1:0];
      end else begin
        icol_nxt = icol_inc[CW-1:0];
      end
    end

    if (emit_now) begin
      if (ocol_inc >= w_eff) begin
        ocol_nxt     = '0;
        out_slot_nxt = out_slot_r + SLOT_W'(1);
        orow_nxt     = (orow_inc >= h_e) ? '0 : orow_inc[IMG_H_W-1:0];
      end else begin
        ocol_nxt = ocol_inc[CW-1:0];
      end
    end

    if (pix_acc && !emit_now) begin
      pending_nxt = pending_r + PW'(1);
    end else if (!pix_acc && emit_now) begin
      pending_nxt = pending_r - PW'(1);
    end

    if (emit_now && !out_pop) begin
      credit_nxt = credit_r + COUNT_W'(1);
    end else if (!emit_now && out_pop) begin
      credit_nxt = credit_r - COUNT_W'(1);
    end
  end

  // neighbour masks for the result about to be released
  always_comb begin
    emit_ctl.valid     = emit_now;
    emit_ctl.slot      = out_slot_r;
    emit_ctl.row_ok[0] = orow_r != '0 && orow_e <= h_e;
    emit_ctl.row_ok[1] = orow_e < h_e;
    emit_ctl.row_ok[2] = orow_inc < h_e;
    emit_ctl.col_ok[0] = ocol_r != '0 && ocol_e <= w_eff;
    emit_ctl.col_ok[1] = ocol_e < w_eff;
    emit_ctl.col_ok[2] = ocol_inc < w_eff;
    emit_ctl.last      = orow_inc == h_e && ocol_inc == w_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r     <= '0;
      irow_r     <= '0;
      in_slot_r  <= '0;
      ocol_r     <= '0;
      orow_r     <= '0;
      out_slot_r <= '0;
      pending_r  <= '0;
      credit_r   <= '0;
      emit_b_r   <= '0;
    end else begin
      icol_r     <= icol_nxt;
      irow_r     <= irow_nxt;
      in_slot_r  <= in_slot_nxt;
      ocol_r     <= ocol_nxt;
      orow_r     <= orow_nxt;
      out_slot_r <= out_slot_nxt;
      pending_r  <= pending_nxt;
      credit_r   <= credit_nxt;
      emit_b_r   <= emit_ctl;
    end
  end

  always_ff @(posedge clk) begin
    emit_col_b_r <= ocol_r;
  end

  assign wr.en      = pix_acc;
  assign wr.slot    = in_slot_r;
  assign wr.data    = in_pixel;
  assign wr_col     = icol_r;
  // centre and right-hand columns of the window; left comes from the cache
  assign rd_col_a   = ocol_r;
  assign rd_col_b   = ocol_r + CW'(1);
  assign emit_b     = emit_b_r;
  assign emit_col_b = emit_col_b_r;

  `ICV_ASSERT(a_pending_bound, clk, rst_n, pending_r <= PW'(MAX_WIDTH + 1), "pending count past one row plus one")
  `ICV_ASSERT(a_credit_bound, clk, rst_n, credit_r <= COUNT_W'(FIFO_DEPTH), "outstanding results past queue depth")
  `ICV_ASSERT_IMPLIES(a_pop_has_credit, clk, rst_n, out_pop, credit_r != '0, "result taken without credit")

endmodule
`default_nettype wire

// File: src/icv_mac.sv
// Window assembly with forwarding, nine multiplies and the adder tree
`default_nettype none
module icv_mac #(
  parameter int MAX_WIDTH = icv_pkg::MAX_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  icv_pkg::wr_ctl_t                        wr,
  input  logic [$clog2(MAX_WIDTH)-1:0]            wr_col,
  input  icv_pkg::col_word_t                      rd_data_a,
  input  icv_pkg::col_word_t                      rd_data_b,
  input  icv_pkg::emit_ctl_t                      emit_b,
  input  logic [$clog2(MAX_WIDTH)-1:0]            emit_col_b,
  input  logic [2:0][icv_pkg::TAPS_W-1:0]         taps,
  output logic                                    push,
  output icv_pkg::result_t                        push_data
);
  import icv_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // last cycle's write, for read-during-write on the store
  wr_ctl_t       wr_q_r;
  logic [CW-1:0] wr_q_col_r;

  // left column of the window, kept coherent with every store write
  col_word_t     cache_r, cache_nxt;
  logic [CW-1:0] cache_col_r, cache_col_nxt;

  col_word_t     fresh0, fresh1;
  col_word_t     cols [3];
  logic [CW-1:0] col_plus;

  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic                     valid_c_r, last_c_r;
  logic signed [RSUM_W-1:0] rsum_r [3];
  logic signed [RSUM_W-1:0] rsum_nxt [3];
  logic                     valid_d_r, last_d_r;

  assign col_plus = emit_col_b + CW'(1);

  always_comb begin
    fresh0 = rd_data_a;
    fresh1 = rd_data_b;
    if (wr_q_r.en && wr_q_col_r == emit_col_b) begin
      fresh0[wr_q_r.slot] = wr_q_r.data;
    end
    if (wr_q_r.en && wr_q_col_r == col_plus) begin
      fresh1[wr_q_r.slot] = wr_q_r.data;
    end
  end

  always_comb begin
    cache_nxt     = emit_b.valid ? fresh0 : cache_r;
    cache_col_nxt = emit_b.valid ? emit_col_b : cache_col_r;
    if (wr.en && wr_col == cache_col_nxt) begin
      cache_nxt[wr.slot] = wr.data;
    end
  end

  assign cols[0] = cache_r;
  assign cols[1] = fresh0;
  assign cols[2] = fresh1;

  // row i reads slot (slot + i - 1); tap is flipped: kernel (2-i, 2-j)
  always_comb begin
    logic [SLOT_W-1:0]        lane;
    pixel_t                   pix;
    logic signed [TAP_W-1:0]  tap;
    lane = '0;
    pix  = '0;
    tap  = '0;
    for (int i = 0; i < 3; i++) begin
      lane = emit_b.slot + SLOT_W'(i) - SLOT_W'(1);
      for (int j = 0; j < 3; j++) begin
        pix = (emit_b.row_ok[i] && emit_b.col_ok[j]) ? cols[j][lane] : '0;
        tap = taps[2-i][TAP_W*(2-j) +: TAP_W];
        prod_nxt[3*i+j] = PROD_W'($signed({1'b0, pix})) * PROD_W'(tap);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum_nxt[i] = RSUM_W'(prod_r[3*i]) + RSUM_W'(prod_r[3*i+1]) + RSUM_W'(prod_r[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_q_r    <= '0;
      valid_c_r <= 1'b0;
      valid_d_r <= 1'b0;
    end else begin
      wr_q_r    <= wr;
      valid_c_r <= emit_b.valid;
      valid_d_r <= valid_c_r;
    end
  end

  always_ff @(posedge clk) begin
    wr_q_col_r  <= wr_col;
    cache_r     <= cache_nxt;
    cache_col_r <= cache_col_nxt;
    last_c_r    <= emit_b.last;
    last_d_r    <= last_c_r;
    for (int k = 0; k < 9; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    for (int i = 0; i < 3; i++) begin
      rsum_r[i] <= rsum_nxt[i];
    end
  end

  assign push                     = valid_d_r;
  assign push_data.filtered_value = RES_W'(rsum_r[0]) + RES_W'(rsum_r[1]) + RES_W'(rsum_r[2]);
  assign push_data.last_of_frame  = last_d_r;

endmodule
`default_nettype wire

// File: src/icv_out_fifo.sv
// Result queue between the datapath and the output channel
`default_nettype none
module icv_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  icv_pkg::result_t push_data,
  input  logic             pop,
  output logic             out_valid,
  output icv_pkg::result_t out_data
);
  import icv_pkg::*;

  `include "image_convolution_3x3_macros.svh"

  result_t                fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = count_r != '0;
  assign out_data  = fifo_r[rd_ptr_r];

  `ICV_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push && !pop, count_r < COUNT_W'(FIFO_DEPTH), "result queue overflow")
  `ICV_ASSERT_NEXT(a_fill_shows, clk, rst_n, push && count_r == '0, out_valid, "pushed result not shown")
  `ICV_ASSERT_NEXT(a_drain_empties, clk, rst_n, pop && !push && count_r == COUNT_W'(1), !out_valid, "queue still valid after last pop")

endmodule
`default_nettype wire

// File: src/image_convolution_3x3.sv
// Top level of the 3x3 convolution block: registers and module wiring
//
// Usage notes
//  - in_chan carries one transaction per pixel in raster order (func = 0) or a
//    flush tick (func = 1). out_chan carries one filtered value per position,
//    signed with 8 fractional bits; last_of_frame marks the bottom-right pixel.
//  - Results trail the pixels by one row plus one pixel. Once a frame is in,
//    each flush tick releases one pending result; pixels of the next frame
//    push them out as well. Flush ticks mid-frame do nothing.
//  - Throughput: one transaction per clock while in_chan.ready is high, set by
//    the single write port of the line store and one column read pair per
//    released result. A released result passes through the store read,
//    multiply, row sums and queue registers before it shows on out_chan.
//  - Up to 8 results may be in flight or queued. While the receiver stalls
//    the queue fills; in_chan.ready falls only once 8 are outstanding.
//  - Reset (synchronous, active low) clears all counters, the queue and the
//    registers to 256 x 256 with an identity kernel. The line store is not
//    cleared: no result reads an entry before it is written.
//  - Configuration writes are taken at any edge with cfg_we high, and belong
//    while no results are outstanding.
`default_nettype none
module image_convolution_3x3 #(
  parameter int MAX_WIDTH = icv_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  icv_in_if.sink                             in_chan,
  icv_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [icv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import icv_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [IMG_W_W-1:0]     image_width_r;
  logic [IMG_H_W-1:0]     image_height_r;
  logic [2:0][TAPS_W-1:0] taps_r;

  // sequencer to store and datapath
  wr_ctl_t       wr;
  logic [CW-1:0] wr_col, rd_col_a, rd_col_b, emit_col_b;
  emit_ctl_t     emit_b;
  col_word_t     rd_data_a, rd_data_b;

  // datapath to queue
  logic    push, out_pop, in_ready;
  result_t push_data, out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      taps_r[0]      <= TAPS_TOP_RST;
      taps_r[1]      <= TAPS_MIDDLE_RST;
      taps_r[2]      <= TAPS_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IMG_H_W-1:0];
        CFG_TAPS_TOP:     taps_r[0]      <= cfg_wdata;
        CFG_TAPS_MIDDLE:  taps_r[1]      <= cfg_wdata;
        CFG_TAPS_BOTTOM:  taps_r[2]      <= cfg_wdata;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // counters, release decision and store addressing
  icv_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_func      (in_chan.func),
    .in_pixel     (in_chan.pixel_value),
    .in_ready     (in_ready),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .out_pop      (out_pop),
    .wr           (wr),
    .wr_col       (wr_col),
    .rd_col_a     (rd_col_a),
    .rd_col_b     (rd_col_b),
    .emit_b       (emit_b),
    .emit_col_b   (emit_col_b)
  );

  // four row slots of line storage
  icv_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
    .clk       (clk),
    .wr        (wr),
    .wr_col    (wr_col),
    .rd_col_a  (rd_col_a),
    .rd_col_b  (rd_col_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // window, multiplies and sum
  icv_mac #(.MAX_WIDTH(MAX_WIDTH)) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .wr_col     (wr_col),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b),
    .emit_b     (emit_b),
    .emit_col_b (emit_col_b),
    .taps       (taps_r),
    .push       (push),
    .push_data  (push_data)
  );

  // output queue decouples the receiver from the pipeline
  icv_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (out_pop),
    .out_valid (out_chan.valid),
    .out_data  (out_data)
  );

  assign out_pop                 = out_chan.valid && out_chan.ready;
  assign out_chan.filtered_value = out_data.filtered_value;
  assign out_chan.last_of_frame  = out_data.last_of_frame;
  assign in_chan.ready           = in_ready;

endmodule
`default_nettype wire
